// ===== rtl/lzn_pkg.sv =====
// ----------------------------------------------------------------------------
// lzn_pkg: shared types and constants for the landmark z-score normalizer
// Widths of the fixed-point datapath and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lzn_pkg;

  localparam int MAX_POINTS  = 32;
  localparam int COORD_WIDTH = 18;
  localparam int SCORE_W     = 16;
  localparam int FRAC_BITS   = 24;

  localparam int LG      = $clog2(MAX_POINTS);
  localparam int ADDR_W  = LG;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int SUM_W   = COORD_WIDTH + LG;
  localparam int DIFF_W  = COORD_WIDTH + LG + 2;
  localparam int MAG_W   = DIFF_W - 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int T_W     = SQ_W + LG;
  localparam int P_W     = SQ_W + CNT_W;
  localparam int NUM_W   = P_W + FRAC_BITS;
  localparam int Q_W     = LG + FRAC_BITS + 1;
  localparam int ROOT_W  = (Q_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int SREM_W  = ROOT_W + 2;
  localparam int ITER_W  = $clog2(Q_W + 1);
  localparam int EXT_W   = ROOT_W + SCORE_W;
  localparam int POINT_W = 3 * COORD_WIDTH;
  localparam int IN_DATA_W  = ((POINT_W + 7) / 8) * 8;
  localparam int OUT_BITS   = 3 * SCORE_W + 4;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;       // input beat taken
    logic              clr_t;      // clear deviation sums
    logic              diff;       // form n*c - S from read data
    logic              square;     // square the deviation magnitude
    logic              acc;        // add squares into T
    logic              muln;       // numerator n*D^2 << 24
    logic              div_init;
    logic              div_step;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              pack;       // load output register
    logic              pack_last;
    logic              end_set;    // clear count, sums, drop flag
    logic [ADDR_W-1:0] addr;       // store read address
  } lzn_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } lzn_status_t;

endpackage

// ===== rtl/lzn_ram.sv =====
// ----------------------------------------------------------------------------
// lzn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lzn_datapath.sv =====
// ----------------------------------------------------------------------------
// lzn_datapath: point store, axis sums and score arithmetic
// Three axis lanes: deviation, square, restoring divider and square root.
// ----------------------------------------------------------------------------
module lzn_datapath import lzn_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  lzn_cmd_t                      cmd,
  output lzn_status_t                   status,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  output logic [OUT_DATA_W-1:0]         out_data,
  output logic                          out_last
);

  localparam logic [EXT_W-1:0] SAT_POS = EXT_W'((2 ** (SCORE_W - 1)) - 1);
  localparam logic [EXT_W-1:0] SAT_NEG = EXT_W'(2 ** (SCORE_W - 1));

  logic [CNT_W-1:0]               count;
  logic                           drop;
  logic                           full;
  logic signed [COORD_WIDTH-1:0]  cin  [3];
  logic signed [SUM_W-1:0]        sum  [3];
  logic [T_W-1:0]                 tsum [3];
  logic signed [DIFF_W-1:0]       diff [3];
  logic [SQ_W-1:0]                sq   [3];
  logic [T_W-1:0]                 rem  [3];
  logic [Q_W-1:0]                 numlo[3];
  logic [Q_W-1:0]                 quo  [3];
  logic [SREM_W-1:0]              srem [3];
  logic [ROOT_W-1:0]              root [3];
  logic [RAD_W-1:0]               rad  [3];
  logic [2:0]                     flat;
  logic [POINT_W-1:0]             rdata;
  logic signed [COORD_WIDTH-1:0]  rc   [3];
  logic [SCORE_W-1:0]             score[3];

  assign full         = (count == CNT_W'(MAX_POINTS));
  assign status.count = count;
  assign cin[0] = x_coord;
  assign cin[1] = y_coord;
  assign cin[2] = z_coord;

  // Point store, x in the low bits
  lzn_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({z_coord, y_coord, x_coord}),
    .raddr (cmd.addr),
    .rdata (rdata)
  );

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rc[a]   = rdata[a*COORD_WIDTH +: COORD_WIDTH];
      flat[a] = (tsum[a] == '0);
    end
  end

  // Saturated signed score per axis
  always_comb begin
    logic [EXT_W-1:0] k;
    for (int a = 0; a < 3; a++) begin
      k = EXT_W'(root[a]);
      if (flat[a]) begin
        score[a] = '0;
      end else if (diff[a] < 0) begin
        score[a] = (k > SAT_NEG) ? SAT_NEG[SCORE_W-1:0] : SCORE_W'(-k);
      end else begin
        score[a] = (k > SAT_POS) ? SAT_POS[SCORE_W-1:0] : k[SCORE_W-1:0];
      end
    end
  end

  // Load bookkeeping: count, sums, drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
      for (int a = 0; a < 3; a++) sum[a] <= '0;
    end else if (cmd.end_set) begin
      count <= '0;
      drop  <= 1'b0;
      for (int a = 0; a < 3; a++) sum[a] <= '0;
    end else if (cmd.load) begin
      if (full) begin
        drop <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
        for (int a = 0; a < 3; a++) sum[a] <= sum[a] + SUM_W'(cin[a]);
      end
    end
  end

  // Arithmetic lanes
  always_ff @(posedge clk) begin
    logic [MAG_W-1:0]   mag;
    logic [P_W-1:0]     prod;
    logic [NUM_W-1:0]   num;
    logic [T_W:0]       trial;
    logic [SREM_W-1:0]  ssh;
    logic [SREM_W-1:0]  strial;
    for (int a = 0; a < 3; a++) begin
      if (cmd.clr_t) tsum[a] <= '0;
      if (cmd.diff) begin
        diff[a] <= DIFF_W'($signed({1'b0, count}) * rc[a]) - DIFF_W'(sum[a]);
      end
      if (cmd.square) begin
        mag    = (diff[a] < 0) ? MAG_W'(-diff[a]) : MAG_W'(diff[a]);
        sq[a] <= mag * mag;
      end
      if (cmd.acc) tsum[a] <= tsum[a] + T_W'(sq[a]);
      if (cmd.muln) begin
        prod     = P_W'(sq[a]) * P_W'(count);
        num      = {prod, {FRAC_BITS{1'b0}}};
        rem[a]   <= T_W'(num[NUM_W-1:Q_W]);
        numlo[a] <= num[Q_W-1:0];
      end
      // Restoring division, one quotient bit a cycle
      if (cmd.div_step) begin
        trial = {rem[a], numlo[a][Q_W-1]};
        if (trial >= {1'b0, tsum[a]}) begin
          rem[a] <= T_W'(trial - {1'b0, tsum[a]});
          quo[a] <= {quo[a][Q_W-2:0], 1'b1};
        end else begin
          rem[a] <= trial[T_W-1:0];
          quo[a] <= {quo[a][Q_W-2:0], 1'b0};
        end
        numlo[a] <= {numlo[a][Q_W-2:0], 1'b0};
      end
      if (cmd.div_init) quo[a] <= '0;
      // Digit-by-digit square root, one root bit a cycle
      if (cmd.sqrt_init) begin
        rad[a]  <= RAD_W'(quo[a]);
        srem[a] <= '0;
        root[a] <= '0;
      end
      if (cmd.sqrt_step) begin
        ssh    = {srem[a][SREM_W-3:0], rad[a][RAD_W-1 -: 2]};
        strial = {root[a], 2'b01};
        if (ssh >= strial) begin
          srem[a] <= ssh - strial;
          root[a] <= {root[a][ROOT_W-2:0], 1'b1};
        end else begin
          srem[a] <= ssh;
          root[a] <= {root[a][ROOT_W-2:0], 1'b0};
        end
        rad[a] <= {rad[a][RAD_W-3:0], 2'b00};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.pack) begin
      out_data <= OUT_DATA_W'({drop, flat, score[2], score[1], score[0]});
      out_last <= cmd.pack_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

// ===== rtl/lzn_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzn_ctrl: sequencer for load, deviation pass and score pass
// Walks the stored points twice and steps the divider and root units.
// ----------------------------------------------------------------------------
module lzn_ctrl import lzn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  lzn_status_t status,
  output lzn_cmd_t    cmd
);

  typedef enum logic [3:0] {
    LOAD, P1_RD, P1_DF, P1_SQ, P1_AC,
    P2_RD, P2_DF, P2_SQ, P2_MN, P2_DV, P2_SI, P2_RT, P2_PK, P2_WO
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] idx;
  logic [ITER_W-1:0] iter;
  logic              is_last;
  logic              in_beat;
  logic              out_beat;

  assign is_last  = ((CNT_W'(idx) + CNT_W'(1)) == status.count);
  assign in_ready = (state == LOAD);
  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Commands decoded from state
  always_comb begin
    cmd           = '0;
    cmd.addr      = idx;
    cmd.load      = in_beat;
    cmd.clr_t     = in_beat && in_last;
    cmd.diff      = (state == P1_DF) || (state == P2_DF);
    cmd.square    = (state == P1_SQ) || (state == P2_SQ);
    cmd.acc       = (state == P1_AC);
    cmd.muln      = (state == P2_MN);
    cmd.div_init  = (state == P2_MN);
    cmd.div_step  = (state == P2_DV);
    cmd.sqrt_init = (state == P2_SI);
    cmd.sqrt_step = (state == P2_RT);
    cmd.pack      = (state == P2_PK);
    cmd.pack_last = is_last;
    cmd.end_set   = (state == P2_WO) && out_ready && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      idx       <= '0;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          idx <= '0;
          if (in_beat && in_last) state <= P1_RD;
        end
        P1_RD: state <= P1_DF;
        P1_DF: state <= P1_SQ;
        P1_SQ: state <= P1_AC;
        P1_AC: begin
          if (is_last) begin
            idx   <= '0;
            state <= P2_RD;
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= P1_RD;
          end
        end
        P2_RD: state <= P2_DF;
        P2_DF: state <= P2_SQ;
        P2_SQ: state <= P2_MN;
        P2_MN: begin
          iter  <= '0;
          state <= P2_DV;
        end
        P2_DV: begin
          if (iter == ITER_W'(Q_W - 1)) begin
            iter  <= '0;
            state <= P2_SI;
          end else begin
            iter <= iter + ITER_W'(1);
          end
        end
        // Quotient complete, load the root unit
        P2_SI: state <= P2_RT;
        P2_RT: begin
          if (iter == ITER_W'(ROOT_W - 1)) begin
            state <= P2_PK;
          end else begin
            iter <= iter + ITER_W'(1);
          end
        end
        P2_PK: begin
          out_valid <= 1'b1;
          state     <= P2_WO;
        end
        P2_WO: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (is_last) begin
              state <= LOAD;
            end else begin
              idx   <= idx + ADDR_W'(1);
              state <= P2_RD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    out_beat && is_last |=> in_ready)
    else $error("set end did not return to load");

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == P2_WO)
    else $error("result valid outside output wait");

endmodule

// ===== rtl/landmark_zscore_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// landmark_zscore_normalizer_core: per-axis z-score of a stored point set
// Stores up to MAX_POINTS 3-D points, then emits population z-scores (Q4.12).
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// s_axis   in   tdata: x_coord, y_coord, z_coord; tlast: last_point
// m_axis   out  tdata: x/y/z_score, flat_axis, overflowed; tlast: last_score
//
// Loading takes one cycle a point. The deviation pass then reads, forms the
// deviation of, squares and accumulates each point in turn; the score pass
// forms each result with the 30-step restoring divider and 15-step root unit of each lane.
// Reset is synchronous and empties the set. Input is held off from the last
// point until the final result is taken; a stalled result holds its register.
// ----------------------------------------------------------------------------
module landmark_zscore_normalizer_core import lzn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // x_coord, y_coord, z_coord
  input  logic                  s_axis_tlast,  // last_point
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // x, y, z_score, flat_axis, overflowed
  output logic                  m_axis_tlast   // last_score
);

  lzn_cmd_t    cmd;
  lzn_status_t status;

  lzn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lzn_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .x_coord  (s_axis_tdata[COORD_WIDTH-1:0]),
    .y_coord  (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .z_coord  (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .out_data (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule
